// ===== hw/rtl/hwm_pkg.sv =====
// Shared types and constants for the Harris window moment block.
`default_nettype none
package hwm_pkg;

	localparam int unsigned COUNT_W = 11;
	localparam int unsigned GRAD_W  = 9;
	localparam int unsigned FRAC_W  = 8;
	localparam int unsigned IG_W    = 20;
	localparam int unsigned XX_W    = 47;
	localparam int unsigned XY_W    = 48;
	localparam int unsigned S_W     = 30;
	localparam int unsigned SCORE_W = 64;
	localparam int unsigned BS_W    = 6;
	localparam int unsigned K_W     = 16;
	localparam int unsigned CFG_D_W = 16;

	localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 6'd7;
	localparam logic [K_W-1:0]  K_COEF_RST     = 16'd2621;

	typedef enum logic {
		CFG_BLOCK_SIZE = 1'b0,
		CFG_K_COEF     = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic accept;
		logic mul;
		logic accum;
		logic snap;
		logic prod;
		logic term;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hwm_ctrl.sv =====
// Sequencer for sample accumulation, response computation and result handoff.
`default_nettype none
module hwm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire hwm_pkg::status_t status,
	output hwm_pkg::cmd_t        cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_SNAP,
		S_PROD,
		S_TERM,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.mul    = (state_q == S_MUL);
		cmd.accum  = (state_q == S_ACC);
		cmd.snap   = (state_q == S_SNAP);
		cmd.prod   = (state_q == S_PROD);
		cmd.term   = (state_q == S_TERM);
		cmd.emit   = (state_q == S_EMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_MUL;
				end
				S_MUL:  state_q <= S_ACC;
				S_ACC: begin
					state_q <= status.last ? S_SNAP : S_IDLE;
				end
				S_SNAP: state_q <= S_PROD;
				S_PROD: state_q <= S_TERM;
				S_TERM: state_q <= S_EMIT;
				S_EMIT: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_last_snaps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC && status.last) |=> (state_q == S_SNAP))
		else $error("last sample did not start response");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");

	a_accept_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_MUL))
		else $error("accepted request not processed");

endmodule
`default_nettype wire

// ===== hw/rtl/hwm_datapath.sv =====
// Gradient weighting, moment accumulators, response pipeline and result registers.
`default_nettype none
module hwm_datapath #(
	parameter int unsigned MAX_BLOCK = 45
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire hwm_pkg::cmd_t                       cmd,
	output hwm_pkg::status_t                         status,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_index,
	input  wire logic [hwm_pkg::CFG_D_W-1:0]         cfg_data,
	input  wire logic [hwm_pkg::FRAC_W-1:0]          frac_x,
	input  wire logic [hwm_pkg::FRAC_W-1:0]          frac_y,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gx_left,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gx_center,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gx_right,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gx_above,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gx_below,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gy_left,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gy_center,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gy_right,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gy_above,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gy_below,
	output logic [hwm_pkg::XX_W-1:0]                 sum_xx,
	output logic [hwm_pkg::XX_W-1:0]                 sum_yy,
	output logic signed [hwm_pkg::XY_W-1:0]          sum_xy,
	output logic signed [hwm_pkg::S_W-1:0]           sum_x,
	output logic signed [hwm_pkg::S_W-1:0]           sum_y,
	output logic signed [hwm_pkg::SCORE_W-1:0]       corner_score
);

	localparam logic [hwm_pkg::BS_W-1:0] MaxBs = hwm_pkg::BS_W'(MAX_BLOCK);
	localparam int unsigned PROD_W = 2 * hwm_pkg::IG_W;

	// Ix*256 = 256*(L+C+A) + (R-L)*fx + (B-A)*fy
	function automatic logic signed [19:0] weigh(
		input logic signed [8:0] l,
		input logic signed [8:0] c,
		input logic signed [8:0] r,
		input logic signed [8:0] a,
		input logic signed [8:0] b,
		input logic [7:0]        fx,
		input logic [7:0]        fy
	);
		logic signed [10:0] base;
		logic signed [9:0]  dh;
		logic signed [9:0]  dv;
		logic signed [18:0] ph;
		logic signed [18:0] pv;
		base  = 11'(l) + 11'(c) + 11'(a);
		dh    = 10'(r) - 10'(l);
		dv    = 10'(b) - 10'(a);
		ph    = 19'(dh) * 19'($signed({1'b0, fx}));
		pv    = 19'(dv) * 19'($signed({1'b0, fy}));
		weigh = 20'($signed({base, 8'd0})) + 20'(ph) + 20'(pv);
	endfunction

	logic [hwm_pkg::BS_W-1:0]    block_size_q;
	logic [hwm_pkg::K_W-1:0]     k_coef_q;
	logic [hwm_pkg::BS_W-1:0]    bs_eff;
	logic [2*hwm_pkg::BS_W-1:0]  target;
	logic [hwm_pkg::COUNT_W-1:0] count_q;
	logic [hwm_pkg::COUNT_W-1:0] count_next;

	logic signed [hwm_pkg::IG_W-1:0]   ix_s1, iy_s1;
	logic signed [2*hwm_pkg::IG_W-1:0] pxx_s2, pyy_s2, pxy_s2;

	logic [hwm_pkg::XX_W-1:0] acc_xx_q, acc_yy_q;
	logic [hwm_pkg::XY_W-1:0] acc_xy_q;
	logic [hwm_pkg::S_W-1:0]  acc_x_q, acc_y_q;

	logic [hwm_pkg::XX_W-1:0]  xx_s4, yy_s4;
	logic [hwm_pkg::XY_W-1:0]  xy_s4;
	logic [hwm_pkg::S_W-1:0]   x_s4, y_s4;
	logic [30:0]               a_s4, b_s4;
	logic signed [31:0]        c_s4;
	logic [31:0]               s_s4;
	logic [63:0]               ab_s5, s2_s5;
	logic signed [63:0]        cc_s5;
	logic [63:0]               hi_s6, d_s6;
	logic [15:0]               lo_s6;
	logic [31:0]               lo_full;

	logic [hwm_pkg::XX_W-1:0]  sum_xx_q, sum_yy_q;
	logic [hwm_pkg::XY_W-1:0]  sum_xy_q;
	logic [hwm_pkg::S_W-1:0]   sum_x_q, sum_y_q;
	logic [63:0]               score_q;

	always_comb begin
		if (block_size_q == '0) begin
			bs_eff = hwm_pkg::BS_W'(1);
		end else if (block_size_q > MaxBs) begin
			bs_eff = MaxBs;
		end else begin
			bs_eff = block_size_q;
		end
	end

	assign target      = {{hwm_pkg::BS_W{1'b0}}, bs_eff} * {{hwm_pkg::BS_W{1'b0}}, bs_eff};
	assign count_next  = count_q + hwm_pkg::COUNT_W'(1);
	assign status.last = {1'b0, count_next} >= target;
	assign lo_full     = {16'd0, s2_s5[15:0]} * {16'd0, k_coef_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= hwm_pkg::BLOCK_SIZE_RST;
			k_coef_q     <= hwm_pkg::K_COEF_RST;
		end else if (cfg_we) begin
			unique case (hwm_pkg::cfg_idx_t'(cfg_index))
				hwm_pkg::CFG_BLOCK_SIZE: block_size_q <= cfg_data[hwm_pkg::BS_W-1:0];
				hwm_pkg::CFG_K_COEF:     k_coef_q     <= cfg_data[hwm_pkg::K_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			acc_xx_q <= '0;
			acc_yy_q <= '0;
			acc_xy_q <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
		end else if (cmd.accum) begin
			count_q  <= count_next;
			acc_xx_q <= acc_xx_q + hwm_pkg::XX_W'($unsigned(pxx_s2));
			acc_yy_q <= acc_yy_q + hwm_pkg::XX_W'($unsigned(pyy_s2));
			acc_xy_q <= acc_xy_q + hwm_pkg::XY_W'(pxy_s2);
			acc_x_q  <= acc_x_q + hwm_pkg::S_W'(ix_s1);
			acc_y_q  <= acc_y_q + hwm_pkg::S_W'(iy_s1);
		end else if (cmd.snap) begin
			count_q  <= '0;
			acc_xx_q <= '0;
			acc_yy_q <= '0;
			acc_xy_q <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ix_s1 <= weigh(gx_left, gx_center, gx_right, gx_above, gx_below, frac_x, frac_y);
			iy_s1 <= weigh(gy_left, gy_center, gy_right, gy_above, gy_below, frac_x, frac_y);
		end
		if (cmd.mul) begin
			pxx_s2 <= PROD_W'(ix_s1) * PROD_W'(ix_s1);
			pyy_s2 <= PROD_W'(iy_s1) * PROD_W'(iy_s1);
			pxy_s2 <= PROD_W'(ix_s1) * PROD_W'(iy_s1);
		end
		if (cmd.snap) begin
			xx_s4 <= acc_xx_q;
			yy_s4 <= acc_yy_q;
			xy_s4 <= acc_xy_q;
			x_s4  <= acc_x_q;
			y_s4  <= acc_y_q;
			a_s4  <= acc_xx_q[46:16];
			b_s4  <= acc_yy_q[46:16];
			c_s4  <= $signed(acc_xy_q[47:16]);
			s_s4  <= {1'b0, acc_xx_q[46:16]} + {1'b0, acc_yy_q[46:16]};
		end
		if (cmd.prod) begin
			ab_s5 <= {33'd0, a_s4} * {33'd0, b_s4};
			cc_s5 <= 64'(c_s4) * 64'(c_s4);
			s2_s5 <= {32'd0, s_s4} * {32'd0, s_s4};
		end
		if (cmd.term) begin
			hi_s6 <= {16'd0, s2_s5[63:16]} * {48'd0, k_coef_q};
			lo_s6 <= lo_full[31:16];
			d_s6  <= ab_s5 - $unsigned(cc_s5);
		end
		if (cmd.emit) begin
			sum_xx_q <= xx_s4;
			sum_yy_q <= yy_s4;
			sum_xy_q <= xy_s4;
			sum_x_q  <= x_s4;
			sum_y_q  <= y_s4;
			score_q  <= d_s6 - hi_s6 - {48'd0, lo_s6};
		end
	end

	assign sum_xx       = sum_xx_q;
	assign sum_yy       = sum_yy_q;
	assign sum_xy       = $signed(sum_xy_q);
	assign sum_x        = $signed(sum_x_q);
	assign sum_y        = $signed(sum_y_q);
	assign corner_score = $signed(score_q);

endmodule
`default_nettype wire

// ===== hw/rtl/harris_window_moments_top.sv =====
// Harris window moments top level: sequencer and datapath.
// Each sample is weighed, multiplied and accumulated in turn before the next is taken.
// After the last sample of a window, the snap, product and term steps run and emit registers the result;
//   the next sample is accepted once the response sequence has handed off its result.
// A finished result waits in the output register while new samples are taken.
// Reset clears accumulators, sample count and handshake state; block_size=7, k=2621.
`default_nettype none
module harris_window_moments_top #(
	parameter int unsigned MAX_BLOCK = 45
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic                                cfg_index,
	input  wire logic [hwm_pkg::CFG_D_W-1:0]         cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [hwm_pkg::FRAC_W-1:0]          frac_x,
	input  wire logic [hwm_pkg::FRAC_W-1:0]          frac_y,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gx_left,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gx_center,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gx_right,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gx_above,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gx_below,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gy_left,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gy_center,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gy_right,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gy_above,
	input  wire logic signed [hwm_pkg::GRAD_W-1:0]   gy_below,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [hwm_pkg::XX_W-1:0]                 sum_xx,
	output logic [hwm_pkg::XX_W-1:0]                 sum_yy,
	output logic signed [hwm_pkg::XY_W-1:0]          sum_xy,
	output logic signed [hwm_pkg::S_W-1:0]           sum_x,
	output logic signed [hwm_pkg::S_W-1:0]           sum_y,
	output logic signed [hwm_pkg::SCORE_W-1:0]       corner_score
);

	hwm_pkg::cmd_t    cmd;
	hwm_pkg::status_t status;

	assign cfg_ready = 1'b1;

	hwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	hwm_datapath #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.frac_x       (frac_x),
		.frac_y       (frac_y),
		.gx_left      (gx_left),
		.gx_center    (gx_center),
		.gx_right     (gx_right),
		.gx_above     (gx_above),
		.gx_below     (gx_below),
		.gy_left      (gy_left),
		.gy_center    (gy_center),
		.gy_right     (gy_right),
		.gy_above     (gy_above),
		.gy_below     (gy_below),
		.sum_xx       (sum_xx),
		.sum_yy       (sum_yy),
		.sum_xy       (sum_xy),
		.sum_x        (sum_x),
		.sum_y        (sum_y),
		.corner_score (corner_score)
	);

endmodule
`default_nettype wire
